@@ design/iptrie_pkg.sv @@
// ----------------------------------------------------------------------------
// iptrie_pkg
// Shared constants, field widths, operation codes and the control/status
// bundles between the trie controller and its datapath.
// ----------------------------------------------------------------------------
package iptrie_pkg;

  // default sizing of the node pool and the walk
  localparam int NODES_DEF      = 4096;
  localparam int ADDR_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  // fixed field widths of the request and response
  localparam int OP_W   = 2;
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;

  // operation codes, code 3 is unused and changes nothing
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic init;        // write the root row to zero
    logic load;        // capture the request fields
    logic rd_root;     // read the root row
    logic descend;     // follow the child, read its row
    logic stop_walk;   // latch the number of missing nodes
    logic alloc;       // link a new node under the current one
    logic write_end;   // update the count of the end node
    logic res_load;    // latch the result
    logic res_found;
    logic res_status;
    logic out_load;    // move the result into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_query;
    logic at_end;
    logic child_zero;
    logic count_pos;
    logic depth_zero;
    logic pool_full;
    logic missing_zero;
  } sts_t;

endpackage

@@ design/iptrie_if.sv @@
// ----------------------------------------------------------------------------
// iptrie_if
// Valid/ready channels for trie requests and trie responses.
// ----------------------------------------------------------------------------
interface iptrie_req_if;
  import iptrie_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  prefix_len;

  modport source (output valid, output op, output address, output prefix_len,
                  input ready);
  modport sink   (input valid, input op, input address, input prefix_len,
                  output ready);
endinterface

interface iptrie_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic status;

  modport source (output valid, output found, output status, input ready);
  modport sink   (input valid, input found, input status, output ready);
endinterface

@@ design/iptrie_dp.sv @@
// ----------------------------------------------------------------------------
// iptrie_dp
// Trie datapath: node memory, walk registers, allocation counter, count
// saturation and the result/output registers.
// ----------------------------------------------------------------------------
module iptrie_dp #(
  parameter int NODES      = iptrie_pkg::NODES_DEF,
  parameter int ADDR_BITS  = iptrie_pkg::ADDR_BITS_DEF,
  parameter int COUNT_BITS = iptrie_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [iptrie_pkg::OP_W-1:0]      in_op,
  input  logic [iptrie_pkg::ADDR_W-1:0]    in_address,
  input  logic [iptrie_pkg::LEN_W-1:0]     in_prefix_len,
  input  iptrie_pkg::cmd_t                 cmd,
  output iptrie_pkg::sts_t                 sts,
  output logic                             out_found,
  output logic                             out_status
);
  import iptrie_pkg::*;

  localparam int IDX_W = $clog2(NODES);
  localparam int LW    = $clog2(ADDR_BITS + 1);
  localparam int ROW_W = 2 * IDX_W + COUNT_BITS;
  localparam int SUM_W = ((IDX_W > LW) ? IDX_W : LW) + 1;
  localparam int CH0_LO = COUNT_BITS;
  localparam int CH1_LO = COUNT_BITS + IDX_W;

  // node memory: one row per node, {child1, child0, count}
  logic [ROW_W-1:0] mem [NODES];
  logic [ROW_W-1:0] rdata;

  logic [OP_W-1:0]      op_r;
  logic [ADDR_BITS-1:0] addr_sh;
  logic [LW-1:0]        len_r;
  logic [LW-1:0]        depth;
  logic [IDX_W-1:0]     cur;
  logic [IDX_W-1:0]     nf;
  logic [LW-1:0]        missing;
  logic                 fresh;
  logic                 res_found;
  logic                 res_status;

  logic [ROW_W-1:0]      row;
  logic                  cur_bit;
  logic [IDX_W-1:0]      child;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_new;
  logic [COUNT_BITS-1:0] cnt_max;
  logic [COUNT_BITS-1:0] cnt_min;
  logic [IDX_W-1:0]      new_idx;
  logic [LW-1:0]         miss_calc;
  logic [LW-1:0]         len_clamp;
  logic [ROW_W-1:0]      alloc_row;
  logic [ROW_W-1:0]      end_row;
  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_addr;
  logic [ROW_W-1:0]      mem_wdata;

  // current row: a freshly allocated node is known to be empty
  assign row     = fresh ? '0 : rdata;
  assign cur_bit = addr_sh[ADDR_BITS-1];
  assign child   = cur_bit ? row[CH1_LO +: IDX_W] : row[CH0_LO +: IDX_W];
  assign count   = row[COUNT_BITS-1:0];
  assign new_idx = nf + 1'b1;

  // saturating count update
  assign cnt_max = {1'b0, {(COUNT_BITS-1){1'b1}}};
  assign cnt_min = {1'b1, {(COUNT_BITS-1){1'b0}}};
  always_comb begin
    if (op_r == OP_REMOVE) begin
      count_new = (count == cnt_min) ? count : count - 1'b1;
    end else begin
      count_new = (count == cnt_max) ? count : count + 1'b1;
    end
  end

  // rows to write
  always_comb begin
    alloc_row = row;
    if (cur_bit) begin
      alloc_row[CH1_LO +: IDX_W] = new_idx;
    end else begin
      alloc_row[CH0_LO +: IDX_W] = new_idx;
    end
    end_row = {row[ROW_W-1:COUNT_BITS], count_new};
  end

  // prefix length clamp
  always_comb begin
    if (in_prefix_len > LEN_W'(ADDR_BITS)) begin
      len_clamp = LW'(ADDR_BITS);
    end else begin
      len_clamp = in_prefix_len[LW-1:0];
    end
  end

  assign miss_calc = len_r - depth;

  // status back to the controller
  always_comb begin
    sts.is_query     = (op_r == OP_QUERY);
    sts.at_end       = (op_r == OP_QUERY) ? (depth == LW'(ADDR_BITS)) : (depth == len_r);
    sts.child_zero   = (child == '0);
    sts.count_pos    = !count[COUNT_BITS-1] && (count != '0);
    sts.depth_zero   = (depth == '0);
    sts.pool_full    = (SUM_W'(nf) + SUM_W'(miss_calc)) > SUM_W'(NODES - 1);
    sts.missing_zero = (missing == '0);
  end

  // single memory port, writes and reads never share a cycle
  assign mem_we    = cmd.init | cmd.alloc | cmd.write_end;
  assign mem_re    = cmd.rd_root | cmd.descend;
  assign mem_wdata = cmd.init ? '0 : (cmd.alloc ? alloc_row : end_row);
  always_comb begin
    priority if (cmd.init || cmd.rd_root) begin
      mem_addr = '0;
    end else if (mem_we) begin
      mem_addr = cur;
    end else begin
      mem_addr = child;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  // bump allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      nf <= '0;
    end else if (cmd.alloc) begin
      nf <= new_idx;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      addr_sh <= in_address[ADDR_BITS-1:0];
      len_r   <= len_clamp;
      depth   <= '0;
      cur     <= '0;
      fresh   <= 1'b0;
    end else if (cmd.descend) begin
      addr_sh <= addr_sh << 1;
      depth   <= depth + 1'b1;
      cur     <= child;
    end else if (cmd.alloc) begin
      addr_sh <= addr_sh << 1;
      cur     <= new_idx;
      fresh   <= 1'b1;
    end
    if (cmd.stop_walk) begin
      missing <= miss_calc;
    end else if (cmd.alloc) begin
      missing <= missing - 1'b1;
    end
  end

  // result and output registers
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_found  <= cmd.res_found;
      res_status <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_found  <= res_found;
      out_status <= res_status;
    end
  end

endmodule

@@ design/iptrie_ctrl.sv @@
// ----------------------------------------------------------------------------
// iptrie_ctrl
// Trie controller: sequences the root write, the path walk, the node
// allocation chain and the hand-off into the response register.
// ----------------------------------------------------------------------------
module iptrie_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [iptrie_pkg::OP_W-1:0] in_op,
  input  logic                        out_ready,
  input  iptrie_pkg::sts_t            sts,
  output logic                        in_ready,
  output logic                        out_valid,
  output iptrie_pkg::cmd_t            cmd
);
  import iptrie_pkg::*;

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_CHAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == OP_ADD || in_op == OP_REMOVE || in_op == OP_QUERY) begin
            cmd.rd_root = 1'b1;
            state_next  = ST_WALK;
          end else begin
            cmd.res_load = 1'b1;
            state_next   = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        if (sts.is_query) begin
          if (!sts.depth_zero && sts.count_pos) begin
            cmd.res_load  = 1'b1;
            cmd.res_found = 1'b1;
            state_next    = ST_FINISH;
          end else if (sts.at_end || sts.child_zero) begin
            cmd.res_load = 1'b1;
            state_next   = ST_FINISH;
          end else begin
            cmd.descend = 1'b1;
          end
        end else if (sts.at_end || sts.child_zero) begin
          if (sts.pool_full) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = 1'b1;
            state_next     = ST_FINISH;
          end else begin
            cmd.stop_walk = 1'b1;
            state_next    = ST_CHAIN;
          end
        end else begin
          cmd.descend = 1'b1;
        end
      end
      ST_CHAIN: begin
        if (!sts.missing_zero) begin
          cmd.alloc = 1'b1;
        end else begin
          cmd.write_end = 1'b1;
          cmd.res_load  = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // response valid
  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ design/ipv4_prefix_trie_match.sv @@
// ----------------------------------------------------------------------------
// ipv4_prefix_trie_match
// Binary trie of IPv4 prefixes with saturating signed counts per node.
// ----------------------------------------------------------------------------
// Query: walks from the root to the first positive count, a missing child or
// the last bit. Add/remove: walks, links the missing nodes, updates the count.
// One request at a time; one node memory row per cycle through its single port.
// The response register lets the next request enter while a response waits.
// Reset is synchronous: the INIT state after reset writes the root row; other
// rows are written when their node is allocated.
module ipv4_prefix_trie_match #(
  parameter int NODES      = iptrie_pkg::NODES_DEF,
  parameter int ADDR_BITS  = iptrie_pkg::ADDR_BITS_DEF,
  parameter int COUNT_BITS = iptrie_pkg::COUNT_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  iptrie_req_if.sink  req,
  iptrie_rsp_if.source rsp
);
  import iptrie_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  iptrie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_op     (req.op),
    .out_ready (rsp.ready),
    .sts       (sts),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .cmd       (cmd)
  );

  // node store and walk registers
  iptrie_dp #(
    .NODES      (NODES),
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_op         (req.op),
    .in_address    (req.address),
    .in_prefix_len (req.prefix_len),
    .cmd           (cmd),
    .sts           (sts),
    .out_found     (rsp.found),
    .out_status    (rsp.status)
  );

endmodule

@@ design/iptrie_props.sv @@
// ----------------------------------------------------------------------------
// iptrie_props
// Port-level properties of the trie block, bound to the top level.
// ----------------------------------------------------------------------------
module iptrie_props (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_found,
  input logic rsp_status
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_status))
    else $error("stalled response changed");

  // a dropped update never reports a match
  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_found && rsp_status))
    else $error("response has both found and pool-full");

  // one request in flight: no acceptance right after an acceptance
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted in back-to-back cycles");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_ready)
    else $error("handshake active after reset");

endmodule

bind ipv4_prefix_trie_match iptrie_props u_props (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_found  (rsp.found),
  .rsp_status (rsp.status)
);

@@ bench/ipv4_prefix_trie_match_tb.sv @@
// ----------------------------------------------------------------------------
// ipv4_prefix_trie_match_tb
// Self-checking bench for the IPv4 prefix trie. A directed table covers reset
// state, the field extremes, every operation, long and zero prefixes and
// removal of prefixes that were never added. Random traffic around a set of
// route bases follows, and it runs the node pool full. Every response is
// checked against a bit-accurate trie model in the bench, or a fixed table entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ipv4_prefix_trie_match_tb;
  import iptrie_pkg::*;

  localparam int NODES      = NODES_DEF;
  localparam int ADDR_BITS  = ADDR_BITS_DEF;
  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam int IDX_W      = $clog2(NODES);
  localparam int COUNT_MAX  = 2 ** (COUNT_BITS - 1) - 1;
  localparam int COUNT_MIN  = -(2 ** (COUNT_BITS - 1));

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic found;
    logic status;
  } trie_rsp_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
    logic              fixed;     // response typed in below, not predicted
    logic              found;
    logic              status;
  } dir_row_t;

  logic clk;
  logic rst;

  iptrie_req_if req_ch ();
  iptrie_rsp_if rsp_ch ();

  ipv4_prefix_trie_match dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // trie model state
  logic [IDX_W-1:0]             trie_child [NODES][2];
  logic signed [COUNT_BITS-1:0] trie_count [NODES];
  logic [IDX_W:0]               trie_last;

  trie_rsp_t   pending_rsp [$];
  trie_rsp_t   fixed_rsp;
  logic        fixed_en;
  trie_rsp_t   want_rsp;
  trie_rsp_t   model_rsp;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned rsp_idle_pct;
  logic [ADDR_W-1:0] route_base [16];

  // directed table, fixed responses only where they are obvious
  dir_row_t dir_rows [26] = '{
    '{OP_QUERY,  32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0},
    '{OP_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0},
    '{OP_ADD,    32'h0000_0000, 6'd1,  1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  32'h1234_5678, 6'd0,  1'b1, 1'b1, 1'b0},
    '{OP_REMOVE, 32'h0000_0000, 6'd1,  1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  32'h1234_5678, 6'd0,  1'b1, 1'b0, 1'b0},
    '{OP_ADD,    32'h8000_0000, 6'd1,  1'b1, 1'b0, 1'b0},
    '{OP_REMOVE, 32'h8000_0000, 6'd1,  1'b1, 1'b0, 1'b0},
    '{OP_ADD,    32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  32'hFFFF_FFFF, 6'd0,  1'b1, 1'b1, 1'b0},
    '{OP_QUERY,  32'hFFFF_FFFE, 6'd0,  1'b0, 1'b0, 1'b0},
    '{OP_REMOVE, 32'h0A00_0000, 6'd8,  1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  32'h0A01_0203, 6'd0,  1'b0, 1'b0, 1'b0},
    '{OP_ADD,    32'h0A00_0000, 6'd8,  1'b0, 1'b0, 1'b0},
    '{OP_QUERY,  32'h0A01_0203, 6'd0,  1'b0, 1'b0, 1'b0},
    '{OP_ADD,    32'h0A00_0000, 6'd8,  1'b0, 1'b0, 1'b0},
    '{OP_QUERY,  32'h0A7F_FFFF, 6'd0,  1'b0, 1'b0, 1'b0},
    '{OP_ADD,    32'hFFFF_FFFF, 6'd63, 1'b0, 1'b0, 1'b0},
    '{OP_REMOVE, 32'hFFFF_FFFF, 6'd40, 1'b0, 1'b0, 1'b0},
    '{OP_QUERY,  32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0, 1'b0},
    '{OP_ADD,    32'h5555_5555, 6'd0,  1'b0, 1'b0, 1'b0},
    '{OP_QUERY,  32'h5555_5555, 6'd0,  1'b0, 1'b0, 1'b0},
    '{OP_REMOVE, 32'h5555_5555, 6'd0,  1'b0, 1'b0, 1'b0},
    '{OP_ADD,    32'hC0A8_0000, 6'd16, 1'b0, 1'b0, 1'b0},
    '{OP_QUERY,  32'hC0A8_FFFF, 6'd0,  1'b0, 1'b0, 1'b0}
  };

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // add or remove one prefix, returns 1 when the pool cannot hold its nodes
  function automatic logic trie_update(logic [ADDR_W-1:0] addr,
                                       logic [LEN_W-1:0] len_field, bit is_add);
    int               depth;
    int               missing;
    int               c;
    logic [IDX_W-1:0] node;
    bit               walking;
    logic             b;
    depth = (len_field > ADDR_BITS) ? ADDR_BITS : int'(len_field);
    node = '0;
    missing = 0;
    walking = 1'b1;
    // count the nodes still to be created along the path
    for (int i = 0; i < depth; i++) begin
      b = addr[ADDR_BITS-1-i];
      if (walking && trie_child[node][b] != '0) begin
        node = trie_child[node][b];
      end else begin
        walking = 1'b0;
        missing++;
      end
    end
    if (int'(trie_last) + missing > NODES - 1) begin
      return 1'b1;
    end
    // walk again, linking new nodes from the bump counter
    node = '0;
    for (int i = 0; i < depth; i++) begin
      b = addr[ADDR_BITS-1-i];
      if (trie_child[node][b] == '0) begin
        trie_last++;
        trie_child[node][b] = trie_last[IDX_W-1:0];
      end
      node = trie_child[node][b];
    end
    // saturating count update at the end node
    c = int'(trie_count[node]) + (is_add ? 1 : -1);
    if (c > COUNT_MAX) c = COUNT_MAX;
    if (c < COUNT_MIN) c = COUNT_MIN;
    trie_count[node] = c[COUNT_BITS-1:0];
    return 1'b0;
  endfunction

  // first positive count below the root along the address path
  function automatic logic trie_lookup(logic [ADDR_W-1:0] addr);
    logic [IDX_W-1:0] node;
    logic             b;
    node = '0;
    for (int i = 0; i < ADDR_BITS; i++) begin
      b = addr[ADDR_BITS-1-i];
      if (trie_child[node][b] == '0) return 1'b0;
      node = trie_child[node][b];
      if (trie_count[node] > 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic trie_rsp_t trie_predict(logic [OP_W-1:0] op,
                                             logic [ADDR_W-1:0] addr,
                                             logic [LEN_W-1:0] len_field);
    trie_rsp_t r;
    r = '0;
    case (op)
      OP_ADD:    r.status = trie_update(addr, len_field, 1'b1);
      OP_REMOVE: r.status = trie_update(addr, len_field, 1'b0);
      OP_QUERY:  r.found = trie_lookup(addr);
      default:   r = '0;
    endcase
    return r;
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  // response check, then prediction of the request accepted at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsp.size() == 0) begin
          mismatch_count++;
          $display("%0t: response with no request waiting, found=%0b status=%0b",
                   $time, rsp_ch.found, rsp_ch.status);
        end else begin
          want_rsp = pending_rsp.pop_front();
          if (rsp_ch.found !== want_rsp.found) begin
            mismatch_count++;
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want_rsp.found, rsp_ch.found);
          end
          if (rsp_ch.status !== want_rsp.status) begin
            mismatch_count++;
            $display("%0t: status mismatch, expected %0b, actual %0b",
                     $time, want_rsp.status, rsp_ch.status);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        model_rsp = trie_predict(req_ch.op, req_ch.address, req_ch.prefix_len);
        pending_rsp = {pending_rsp, (fixed_en ? fixed_rsp : model_rsp)};
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // watchdog on a stalled handshake
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // present one request and hold it until accepted
  task automatic send_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                          logic [LEN_W-1:0] len_field, logic fix,
                          trie_rsp_t fix_rsp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.address    <= addr;
    req_ch.prefix_len <= len_field;
    fixed_en          <= fix;
    fixed_rsp         <= fix_rsp;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // hold off until every outstanding response has come back
  task automatic drain_rsp();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // random traffic, mostly prefixes around a few route bases
  task automatic run_random(int unsigned n_items);
    int unsigned       done_items;
    int unsigned       pick;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len_field;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OP_ADD;
      else if (pick < 62) op = OP_REMOVE;
      else if (pick < 96) op = OP_QUERY;
      else op = OP_UNUSED;
      pick = $urandom_range(99);
      if (pick < 60) begin
        addr = route_base[$urandom_range(15)]
             ^ ($urandom & ((32'h1 << $urandom_range(16)) - 32'h1));
      end else if (pick < 95) begin
        addr = $urandom;
      end else begin
        addr = pick[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
      end
      pick = $urandom_range(99);
      if (pick < 6) len_field = '0;
      else if (pick < 14) len_field = LEN_W'($urandom_range(63, 33));
      else if (pick < 30) len_field = LEN_W'($urandom_range(8, 1));
      else len_field = LEN_W'($urandom_range(32, 9));
      send_req(op, addr, len_field, 1'b0, '0);
      if (op != OP_UNUSED) done_items++;
      if ($urandom_range(199) == 0) drain_rsp();
    end
  endtask

  // main sequence
  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.op         = '0;
    req_ch.address    = '0;
    req_ch.prefix_len = '0;
    fixed_en          = 1'b0;
    fixed_rsp         = '0;
    send_idle_pct     = 20;
    rsp_idle_pct      = 65;
    for (int i = 0; i < NODES; i++) begin
      trie_child[i][0] = '0;
      trie_child[i][1] = '0;
      trie_count[i]    = '0;
    end
    trie_last = '0;
    for (int i = 0; i < 16; i++) route_base[i] = $urandom;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].op, dir_rows[i].address, dir_rows[i].prefix_len,
               dir_rows[i].fixed, '{dir_rows[i].found, dir_rows[i].status});
    end

    // random traffic under three idling mixes
    run_random(700);
    drain_rsp();
    send_idle_pct = 65;
    rsp_idle_pct  = 20;
    run_random(700);
    drain_rsp();
    send_idle_pct = 0;
    rsp_idle_pct  = 0;
    run_random(600);

    // wait out the last responses
    drain_rsp();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/iptrie_pkg.sv
design/iptrie_if.sv
design/iptrie_dp.sv
design/iptrie_ctrl.sv
design/ipv4_prefix_trie_match.sv
design/iptrie_props.sv
bench/ipv4_prefix_trie_match_tb.sv
